/* rtl/cae_pkg.sv */
// Shared types, constants and the arctangent table for the Compton angle core.
package cae_pkg;

  // Field widths and formats.
  localparam int unsigned EnergyBits     = 20;
  localparam int unsigned EnergyFracBits = 4;
  localparam int unsigned AngleFracBits  = 8;
  localparam int unsigned AngleBits      = 16;
  localparam int unsigned ArgFrac        = 30;
  localparam int unsigned AtanFrac       = 24;
  localparam int unsigned CordicSteps    = 24;
  localparam int unsigned RestKev        = 511;

  // Quotient width: K << 30 stays below 2^(9 + EnergyFracBits + 30 + 1).
  localparam int unsigned QuotBits = 64;
  // Width of the square root operand and root.
  localparam int unsigned SqBits   = 2 * ArgFrac + 2;
  localparam int unsigned RootBits = ArgFrac + 1;
  // CORDIC datapath widths.
  localparam int unsigned VecBits = ArgFrac + 4;
  localparam int unsigned AngBits = AtanFrac + 10;

  // Status codes.
  typedef enum logic [1:0] {
    StatusValid    = 2'd0,
    StatusEdge     = 2'd1,
    StatusAboveOne = 2'd2,
    StatusZeroDen  = 2'd3
  } status_e;

  typedef struct packed {
    logic [EnergyBits-1:0] incoming_energy;
    logic [EnergyBits-1:0] deposited_energy;
  } in_word_t;

  typedef struct packed {
    logic [AngleBits-1:0]  scatter_angle;
    logic [EnergyBits-1:0] outgoing_energy;
    logic [1:0]            status;
  } out_word_t;

  // Side information that travels with an item down the pipeline.
  typedef struct packed {
    logic [EnergyBits-1:0] eout;
    status_e               status;
  } side_t;

  // atan(2^-i) in degrees with AtanFrac fraction bits.
  function automatic logic [AngBits-1:0] atan_entry(input int unsigned idx);
    logic [AngBits-1:0] val;
    val = '0;
    case (idx)
      0:  val = AngBits'(754974720);
      1:  val = AngBits'(445687602);
      2:  val = AngBits'(235489089);
      3:  val = AngBits'(119537938);
      4:  val = AngBits'(60000934);
      5:  val = AngBits'(30029717);
      6:  val = AngBits'(15018523);
      7:  val = AngBits'(7509719);
      8:  val = AngBits'(3754917);
      9:  val = AngBits'(1877466);
      10: val = AngBits'(938734);
      11: val = AngBits'(469367);
      12: val = AngBits'(234684);
      13: val = AngBits'(117342);
      14: val = AngBits'(58671);
      15: val = AngBits'(29335);
      16: val = AngBits'(14668);
      17: val = AngBits'(7334);
      18: val = AngBits'(3667);
      19: val = AngBits'(1833);
      20: val = AngBits'(917);
      21: val = AngBits'(458);
      22: val = AngBits'(229);
      23: val = AngBits'(115);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/cae_div.sv */
// Pipelined restoring divider of the constant K << 30 by two energy divisors.
module cae_div #(
  parameter int unsigned EBITS = cae_pkg::EnergyBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [EBITS-1:0]            den_a_i,
  input  logic [EBITS-1:0]            den_b_i,
  input  cae_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [cae_pkg::QuotBits-1:0] quot_a_o,
  output logic [cae_pkg::QuotBits-1:0] quot_b_o,
  output cae_pkg::side_t              side_o
);
  import cae_pkg::*;

  // Dividend K << 30; its significant bits set the number of stages.
  localparam logic [QuotBits-1:0] Dividend =
    QuotBits'(RestKev) << (EnergyFracBits + ArgFrac);
  localparam int unsigned NumBits = 9 + EnergyFracBits + ArgFrac;
  localparam int unsigned RemBits = EBITS + 1;

  logic [NumBits:0]    vld_q;
  logic [RemBits-1:0]  rem_a_q [NumBits+1];
  logic [RemBits-1:0]  rem_b_q [NumBits+1];
  logic [NumBits-1:0]  qa_q    [NumBits+1];
  logic [NumBits-1:0]  qb_q    [NumBits+1];
  logic [EBITS-1:0]    da_q    [NumBits+1];
  logic [EBITS-1:0]    db_q    [NumBits+1];
  side_t               sd_q    [NumBits+1];

  // Stage zero holds the operands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_a_q[0] <= '0;
      rem_b_q[0] <= '0;
      qa_q[0]    <= '0;
      qb_q[0]    <= '0;
      da_q[0]    <= den_a_i;
      db_q[0]    <= den_b_i;
      sd_q[0]    <= side_i;
    end
  end

  // One quotient bit per stage for each divisor.
  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic [RemBits-1:0] tra, trb;
    logic               ga, gb;
    assign tra = {rem_a_q[s][RemBits-2:0], Dividend[NumBits-1-s]};
    assign trb = {rem_b_q[s][RemBits-2:0], Dividend[NumBits-1-s]};
    assign ga  = tra >= {1'b0, da_q[s]};
    assign gb  = trb >= {1'b0, db_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[s+1] <= ga ? tra - {1'b0, da_q[s]} : tra;
        rem_b_q[s+1] <= gb ? trb - {1'b0, db_q[s]} : trb;
        qa_q[s+1]    <= {qa_q[s][NumBits-2:0], ga};
        qb_q[s+1]    <= {qb_q[s][NumBits-2:0], gb};
        da_q[s+1]    <= da_q[s];
        db_q[s+1]    <= db_q[s];
        sd_q[s+1]    <= sd_q[s];
      end
    end
  end

  assign valid_o  = vld_q[NumBits];
  assign quot_a_o = QuotBits'(qa_q[NumBits]);
  assign quot_b_o = QuotBits'(qb_q[NumBits]);
  assign side_o   = sd_q[NumBits];

endmodule

/* rtl/cae_sqrt.sv */
// Forms the cosine, classifies it and takes the pipelined integer square root.
module cae_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [cae_pkg::QuotBits-1:0]  quot_a_i,
  input  logic [cae_pkg::QuotBits-1:0]  quot_b_i,
  input  cae_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic signed [cae_pkg::VecBits-1:0] cos_o,
  output logic [cae_pkg::RootBits-1:0]  sin_o,
  output cae_pkg::side_t                side_o
);
  import cae_pkg::*;

  localparam int unsigned CBits = QuotBits + 1;
  localparam logic signed [CBits-1:0] One = CBits'(64'd1 << ArgFrac);
  localparam int unsigned Steps = RootBits;

  // Stage A: cosine in full width, then classify and clamp.
  logic signed [CBits-1:0] c_full;
  assign c_full = One + $signed({1'b0, quot_a_i}) - $signed({1'b0, quot_b_i});

  logic                       va_q;
  logic signed [ArgFrac+1:0]  ca_q;
  side_t                      sa_q;
  logic signed [ArgFrac+1:0]  c_clamp;
  side_t                      s_cls;

  always_comb begin
    s_cls   = side_i;
    c_clamp = (ArgFrac+2)'(One);
    if (side_i.status == StatusValid) begin
      if (c_full < -One) begin
        s_cls.status = StatusEdge;
        c_clamp      = -(ArgFrac+2)'(One);
      end else if (c_full > One) begin
        c_clamp = (ArgFrac+2)'(One);
      end else begin
        c_clamp = (ArgFrac+2)'(c_full);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= c_clamp;
      sa_q <= s_cls;
    end
  end

  // Stage B: radicand 2^60 - c^2.
  logic                   vb_q;
  logic signed [ArgFrac+1:0] cb_q;
  logic [SqBits-1:0]      rad_q;
  side_t                  sb_q;
  logic [ArgFrac:0]       uc;
  logic [2*ArgFrac+1:0]   sq;
  assign uc = ca_q[ArgFrac+1] ? (ArgFrac+1)'(-ca_q) : (ArgFrac+1)'(ca_q);
  assign sq = uc * uc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cb_q  <= ca_q;
      rad_q <= (SqBits'(1) << (2 * ArgFrac)) - SqBits'(sq);
      sb_q  <= sa_q;
    end
  end

  // Digit-by-digit root, one result bit per stage.
  logic                 vr_q  [Steps+1];
  logic [SqBits-1:0]    n_q   [Steps+1];
  logic [SqBits-1:0]    r_q   [Steps+1];
  logic signed [ArgFrac+1:0] cr_q [Steps+1];
  side_t                sr_q  [Steps+1];

  always_comb begin
    vr_q[0] = vb_q;
    n_q[0]  = rad_q;
    r_q[0]  = '0;
    cr_q[0] = cb_q;
    sr_q[0] = sb_q;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_root
    localparam logic [SqBits-1:0] Bit = SqBits'(1) << (2 * (Steps - 1 - s));
    logic ge;
    assign ge = n_q[s] >= (r_q[s] + Bit);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vr_q[s+1] <= vr_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s+1]  <= ge ? n_q[s] - (r_q[s] + Bit) : n_q[s];
        r_q[s+1]  <= ge ? (r_q[s] >> 1) + Bit : r_q[s] >> 1;
        cr_q[s+1] <= cr_q[s];
        sr_q[s+1] <= sr_q[s];
      end
    end
  end

  assign valid_o = vr_q[Steps];
  assign cos_o   = VecBits'(cr_q[Steps]);
  assign sin_o   = RootBits'(r_q[Steps]);
  assign side_o  = sr_q[Steps];

endmodule

/* rtl/cae_cordic.sv */
// Pipelined CORDIC vectoring for atan2 in degrees, with final rounding.
module cae_cordic #(
  parameter int unsigned AFRAC = cae_pkg::AngleFracBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [cae_pkg::VecBits-1:0] cos_i,
  input  logic [cae_pkg::RootBits-1:0]     sin_i,
  input  cae_pkg::side_t                   side_i,
  output logic                             valid_o,
  output logic [cae_pkg::AngleBits-1:0]    angle_o,
  output cae_pkg::side_t                   side_o
);
  import cae_pkg::*;

  localparam logic signed [AngBits-1:0] Deg90  = AngBits'(64'd90 << AtanFrac);
  localparam logic signed [AngBits-1:0] Deg180 = AngBits'(64'd180 << AtanFrac);
  localparam int unsigned Sh = AtanFrac - AFRAC;
  localparam logic [AngleBits-1:0] AMax = AngleBits'(180 << AFRAC);

  logic                         v_q [CordicSteps+1];
  logic signed [VecBits-1:0]    x_q [CordicSteps+1];
  logic signed [VecBits-1:0]    y_q [CordicSteps+1];
  logic signed [AngBits-1:0]    z_q [CordicSteps+1];
  side_t                        s_q [CordicSteps+1];

  // Pre-rotation for a negative cosine.
  logic signed [VecBits-1:0] s_ext;
  assign s_ext = $signed(VecBits'(sin_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cos_i < 0) begin
        x_q[0] <= s_ext;
        y_q[0] <= -cos_i;
        z_q[0] <= Deg90;
      end else begin
        x_q[0] <= cos_i;
        y_q[0] <= s_ext;
        z_q[0] <= '0;
      end
      s_q[0] <= side_i;
    end
  end

  // One micro-rotation per stage; arithmetic shifts floor toward minus infinity.
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    logic signed [VecBits-1:0] xs, ys;
    logic signed [AngBits-1:0] at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = $signed(atan_entry(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end
        s_q[i+1] <= s_q[i];
      end
    end
  end

  // Clamp, round half up and apply the status overrides.
  logic signed [AngBits-1:0] zc;
  logic [AngBits-1:0]        zr;
  logic [AngleBits-1:0]      ang;
  always_comb begin
    zc = z_q[CordicSteps];
    if (zc < 0) begin
      zc = '0;
    end
    if (zc > Deg180) begin
      zc = Deg180;
    end
    if (Sh > 0) begin
      zr = (AngBits'(zc) + (AngBits'(1) << (Sh - 1))) >> Sh;
    end else begin
      zr = AngBits'(zc);
    end
    ang = (zr > AngBits'(AMax)) ? AMax : AngleBits'(zr);
    case (s_q[CordicSteps].status)
      StatusValid: angle_o = ang;
      StatusEdge:  angle_o = AMax;
      default:     angle_o = '0;
    endcase
  end

  assign valid_o = v_q[CordicSteps];
  assign side_o  = s_q[CordicSteps];

endmodule

/* rtl/compton_angle_from_energy_core.sv */
// Top level of the Compton scattering angle core.
//
//  channel | direction | word type               | handshake
//  in      | input     | cae_pkg::in_word_t      | in_valid_i / in_ready_o
//  out     | output    | cae_pkg::out_word_t     | out_valid_o / out_ready_i
//
// One word enters per cycle; a word passes through the operand register and
// 43 bit-per-stage divider stages, two stages that form the cosine and the
// radicand, 31 square root stages, and the pre-rotation register with the
// 24 CORDIC stages. The whole pipeline advances together: it holds when the
// output register is full and not taken. Reset empties every valid bit.
module compton_angle_from_energy_core #(
  parameter int unsigned ANGLE_FRAC_BITS = cae_pkg::AngleFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cae_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cae_pkg::out_word_t out_data_o
);
  import cae_pkg::*;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Input decode: outgoing energy and zero-denominator or negative cases.
  logic [EnergyBits-1:0] ein, edep, eout;
  side_t                 sd_in;
  always_comb begin
    ein          = in_data_i.incoming_energy;
    edep         = in_data_i.deposited_energy;
    eout         = (edep <= ein) ? ein - edep : '0;
    sd_in.eout   = eout;
    sd_in.status = StatusValid;
    if (ein == '0 || ein == edep) begin
      sd_in.status = StatusZeroDen;
    end else if (edep > ein) begin
      sd_in.status = StatusAboveOne;
    end
  end

  // Force divisors nonzero on special cases; the quotient is ignored there.
  logic [EnergyBits-1:0] da, db;
  assign da = (sd_in.status == StatusValid) ? ein  : EnergyBits'(1);
  assign db = (sd_in.status == StatusValid) ? eout : EnergyBits'(1);

  logic                  dv;
  logic [QuotBits-1:0]   qa, qb;
  side_t                 dsd;

  cae_div #(.EBITS(EnergyBits)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i && en),
    .den_a_i(da), .den_b_i(db), .side_i(sd_in),
    .valid_o(dv), .quot_a_o(qa), .quot_b_o(qb), .side_o(dsd)
  );

  logic                       sv;
  logic signed [VecBits-1:0]  cv;
  logic [RootBits-1:0]        sn;
  side_t                      ssd;

  cae_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv),
    .quot_a_i(qa), .quot_b_i(qb), .side_i(dsd),
    .valid_o(sv), .cos_o(cv), .sin_o(sn), .side_o(ssd)
  );

  logic [AngleBits-1:0] angle;
  side_t                osd;

  cae_cordic #(.AFRAC(ANGLE_FRAC_BITS)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sv),
    .cos_i(cv), .sin_i(sn), .side_i(ssd),
    .valid_o(out_valid_o), .angle_o(angle), .side_o(osd)
  );

  // Result word.
  assign out_data_o = '{scatter_angle: angle, outgoing_energy: osd.eout, status: osd.status};

endmodule

/* bench/compton_angle_from_energy_core_tb.sv */
// Self-checking testbench for the Compton scattering angle core.
module compton_angle_from_energy_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cae_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  out_word_t expected_words[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  compton_angle_from_energy_core dut (.*);

  always #1 clk_i = ~clk_i;

  // Floor shift of a signed value; >>> on a signed longint rounds down.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // atan(2^-i) in degrees, 24 fraction bits.
  function automatic longint atan_deg(int i);
    longint tbl[24] = '{754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
                        15018523, 7509719, 3754917, 1877466, 938734, 469367,
                        234684, 117342, 58671, 29335, 14668, 7334,
                        3667, 1833, 917, 458, 229, 115};
    return tbl[i];
  endfunction

  // Arccos of a 30-fraction-bit cosine in degrees with 24 fraction bits.
  function automatic longint arccos_deg(longint c);
    longint unsigned uc;
    longint x, y, z, xs, ys, s;
    uc = (c < 0) ? -c : c;
    s = int_sqrt((64'd1 << 60) - uc * uc);
    z = 0;
    if (c < 0) begin
      x = s;
      y = -c;
      z = 64'sd90 <<< 24;
    end else begin
      x = c;
      y = s;
    end
    for (int i = 0; i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z += atan_deg(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z -= atan_deg(i);
      end
    end
    return z;
  endfunction

  function automatic out_word_t scatter_result(in_word_t w);
    out_word_t r;
    longint unsigned ein, edep, eout, k, ang;
    longint c, one, z;
    ein = 64'(w.incoming_energy);
    edep = 64'(w.deposited_energy);
    eout = (edep <= ein) ? ein - edep : 64'd0;
    ang = 0;
    r.status = StatusValid;
    if (ein == 0 || ein == edep) begin
      r.status = StatusZeroDen;
    end else if (edep > ein) begin
      r.status = StatusAboveOne;
    end else begin
      k = (64'd511 << 4) << 30;
      one = 64'sd1 <<< 30;
      c = one + longint'(k / ein) - longint'(k / eout);
      if (c < -one) begin
        r.status = StatusEdge;
        ang = 64'd180 << 8;
      end else begin
        if (c > one) c = one;
        z = arccos_deg(c);
        if (z < 0) z = 0;
        if (z > (64'sd180 <<< 24)) z = 64'sd180 <<< 24;
        ang = (longint'(z) + (64'd1 << 15)) >> 16;
        if (ang > (64'd180 << 8)) ang = 64'd180 << 8;
      end
    end
    r.scatter_angle = ang[15:0];
    r.outgoing_energy = eout[19:0];
    return r;
  endfunction

  // Send one word after a random gap; valid stays high into a word sent with no gap.
  task automatic send_word(logic [19:0] ein, logic [19:0] edep);
    in_word_t w;
    int unsigned gap;
    w.incoming_energy = ein;
    w.deposited_energy = edep;
    gap = $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    expected_words.push_back(scatter_result(w));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic test_directed();
    send_word(20'd0, 20'd0);
    send_word(20'd0, 20'hFFFFF);
    send_word(20'd1000, 20'd1000);
    send_word(20'd1000, 20'd1001);
    send_word(20'hFFFFF, 20'd0);
    send_word(20'hFFFFF, 20'hFFFFE);
    send_word(20'hFFFFF, 20'd1);
    send_word(20'd1, 20'd0);
    send_word(20'(16 * 662), 20'(16 * 200));
    send_word(20'(16 * 662), 20'(16 * 477));
    send_word(20'(16 * 662), 20'(16 * 600));
    send_word(20'(16 * 1000), 20'(16 * 200));
    send_word(20'(16 * 511), 20'(16 * 341));
    send_word(20'(16 * 511), 20'(16 * 100));
    send_word(20'd2, 20'd1);
    send_word(20'hAAAAA, 20'h55555);
    send_word(20'h55555, 20'h2AAAA);
  endtask

  // Mostly physical events with a deposit no greater than the incoming energy.
  task automatic test_random(int n);
    logic [19:0] ein, edep;
    for (int i = 0; i < n; i++) begin
      ein = 20'($urandom_range(0, 20'hFFFFF));
      edep = 20'($urandom_range(0, 20'hFFFFF));
      case ($urandom_range(0, 9))
        0: edep = 20'($urandom_range(0, 20'hFFFFF));
        1: edep = ein;
        2: ein = 20'($urandom_range(1, 16 * 3000));
        default: ;
      endcase
      if ($urandom_range(0, 9) > 1) edep = (ein == 0) ? 20'd0 : 20'($urandom_range(0, ein));
      send_word(ein, edep);
    end
  endtask

  // Receiver stalls for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(200);
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver side: random stalls per word.
  initial begin
    int unsigned wait_cycles;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        wait_cycles--;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) wait_cycles = $urandom_range(0, 10) * ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Check each accepted result and run the watchdog.
  always @(posedge clk_i) begin
    out_word_t e;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $realtime, out_data_o);
        error_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_data_o.scatter_angle !== e.scatter_angle) begin
          $display("%0t: angle expected %0d actual %0d", $realtime, e.scatter_angle,
                   out_data_o.scatter_angle);
          error_count++;
        end
        if (out_data_o.outgoing_energy !== e.outgoing_energy) begin
          $display("%0t: energy expected %0d actual %0d", $realtime, e.outgoing_energy,
                   out_data_o.outgoing_energy);
          error_count++;
        end
        if (out_data_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                   out_data_o.status);
          error_count++;
        end
      end
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(830);
    in_valid_i <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
